// File: src/assert_macros.svh
// Assertion helpers for the checker module dep_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/dep_pkg.sv
// ----------------------------------------------------------------------------
// dep_pkg
// Widths, codes and types of the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

	localparam int DEPTH    = 64;   // power of two: slot pointers wrap naturally
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int ENTRY_W  = KEY_BITS + TAG_BITS;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DEL_MIN = 2'd1,
		OP_DEL_MAX = 2'd2,
		OP_QUERY   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

endpackage

// File: src/dep_req_if.sv
// ----------------------------------------------------------------------------
// dep_req_if
// Request channel: opcode and the pair to insert.
// ----------------------------------------------------------------------------
interface dep_req_if;
	import dep_pkg::*;

	logic                       valid;
	logic                       ready;
	opcode_t                    opcode;
	logic signed [KEY_BITS-1:0] key;
	logic [TAG_BITS-1:0]        tag;

	modport source (output valid, opcode, key, tag, input ready);
	modport sink (input valid, opcode, key, tag, output ready);
endinterface

// File: src/dep_rsp_if.sv
// ----------------------------------------------------------------------------
// dep_rsp_if
// Response channel: extremes, fill level and status after each request.
// ----------------------------------------------------------------------------
interface dep_rsp_if;
	import dep_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [KEY_BITS-1:0] min_key;
	logic [TAG_BITS-1:0]        min_tag;
	logic signed [KEY_BITS-1:0] max_key;
	logic [TAG_BITS-1:0]        max_tag;
	logic [CNT_W-1:0]           count;
	logic                       is_empty;
	status_t                    status;

	modport source (output valid, min_key, min_tag, max_key, max_tag, count, is_empty,
		status, input ready);
	modport sink (input valid, min_key, min_tag, max_key, max_tag, count, is_empty,
		status, output ready);
endinterface

// File: src/dep_ram.sv
// ----------------------------------------------------------------------------
// dep_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: src/double_ended_priority_queue.sv
// A query or delete passes through S_F_MIN, S_F_MAX, S_F_END and S_DONE to the response
// register, skipping S_F_MAX and S_F_END when the store is empty afterwards; an insert
// scans from the head and shifts the upper pairs up, paced by the single RAM read port
// doing the scan and shift; a duplicate ends the scan at the position where it is found.
// One request is in flight at a time; the next is taken once the response is registered.
// Reset clears the state, fill count, ring head and response valid; the RAM holds no reset value.
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Sorted ring buffer in RAM: head pop for minimum, tail pop for maximum,
// scan and shift for insert.
// ----------------------------------------------------------------------------
module double_ended_priority_queue (
	input logic clk,
	input logic arst_n,
	dep_req_if.sink   req,
	dep_rsp_if.source rsp
);
	import dep_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SCAN_RD  = 9'b000000010,
		S_SCAN_CMP = 9'b000000100,
		S_SHIFT_RD = 9'b000001000,
		S_SHIFT_WR = 9'b000010000,
		S_F_MIN    = 9'b000100000,
		S_F_MAX    = 9'b001000000,
		S_F_END    = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t                     state_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0]        tag_q;
	logic [ADDR_W-1:0]          head_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           pos_q;
	logic [CNT_W-1:0]           idx_q;
	status_t                    status_q;
	logic [ENTRY_W-1:0]         min_q;
	logic [ENTRY_W-1:0]         max_q;

	logic                       rsp_v_q;
	logic signed [KEY_BITS-1:0] rsp_min_key_q;
	logic [TAG_BITS-1:0]        rsp_min_tag_q;
	logic signed [KEY_BITS-1:0] rsp_max_key_q;
	logic [TAG_BITS-1:0]        rsp_max_tag_q;
	logic [CNT_W-1:0]           rsp_cnt_q;
	status_t                    rsp_status_q;

	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_waddr;
	logic [ENTRY_W-1:0]         ram_wdata;
	logic [ADDR_W-1:0]          ram_raddr;
	logic [ENTRY_W-1:0]         ram_rdata;

	logic signed [KEY_BITS-1:0] ent_key;
	logic [TAG_BITS-1:0]        ent_tag;
	logic                       ent_eq;
	logic                       ent_gt;
	logic [CNT_W-1:0]           idx_dec;
	logic                       rsp_load;

	assign ent_key  = ram_rdata[ENTRY_W-1:TAG_BITS];
	assign ent_tag  = ram_rdata[TAG_BITS-1:0];
	assign ent_eq   = (ent_key == key_q) && (ent_tag == tag_q);
	assign ent_gt   = (ent_key > key_q) || ((ent_key == key_q) && (ent_tag > tag_q));
	assign idx_dec  = idx_q - 1'b1;
	assign rsp_load = (state_q == S_DONE) && (!rsp_v_q || rsp.ready);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_q + idx_q[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = head_q + pos_q[ADDR_W-1:0];
		unique case (state_q)
			S_SHIFT_RD: begin
				// place the new pair once the gap reaches its slot
				ram_we    = (idx_q == pos_q);
				ram_wdata = {key_q, tag_q};
				ram_raddr = head_q + idx_dec[ADDR_W-1:0];
			end
			S_SHIFT_WR: ram_we = 1'b1;
			S_F_MIN:    ram_raddr = head_q;
			S_F_MAX:    ram_raddr = head_q + idx_dec[ADDR_W-1:0];
			default:    ;
		endcase
	end

	dep_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			cnt_q    <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
			status_q <= ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						status_q <= ST_DONE;
						pos_q    <= '0;
						unique case (req.opcode) inside
							OP_INSERT: state_q <= S_SCAN_RD;
							OP_DEL_MIN, OP_DEL_MAX: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									cnt_q <= cnt_q - 1'b1;
									if (req.opcode == OP_DEL_MIN) begin
										head_q <= head_q + 1'b1;
									end
								end
								state_q <= S_F_MIN;
							end
							default: state_q <= S_F_MIN;
						endcase
					end
				end
				S_SCAN_RD: begin
					if (pos_q == cnt_q) begin
						// ran off the top: insert at the tail
						if (cnt_q == CNT_W'(DEPTH)) begin
							status_q <= ST_FULL;
							state_q  <= S_F_MIN;
						end else begin
							idx_q   <= cnt_q;
							state_q <= S_SHIFT_RD;
						end
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (ent_eq) begin
						status_q <= ST_DUPLICATE;
						state_q  <= S_F_MIN;
					end else if (ent_gt) begin
						if (cnt_q == CNT_W'(DEPTH)) begin
							status_q <= ST_FULL;
							state_q  <= S_F_MIN;
						end else begin
							idx_q   <= cnt_q;
							state_q <= S_SHIFT_RD;
						end
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					if (idx_q == pos_q) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_F_MIN;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					idx_q   <= idx_dec;
					state_q <= S_SHIFT_RD;
				end
				S_F_MIN: begin
					idx_q   <= cnt_q;
					state_q <= (cnt_q == '0) ? S_DONE : S_F_MAX;
				end
				S_F_MAX: state_q <= S_F_END;
				S_F_END: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			key_q <= req.key;
			tag_q <= req.tag;
		end
		if (state_q == S_F_MIN && cnt_q == '0) begin
			min_q <= '0;
			max_q <= '0;
		end
		if (state_q == S_F_MAX) begin
			min_q <= ram_rdata;
		end
		if (state_q == S_F_END) begin
			max_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_min_key_q <= min_q[ENTRY_W-1:TAG_BITS];
			rsp_min_tag_q <= min_q[TAG_BITS-1:0];
			rsp_max_key_q <= max_q[ENTRY_W-1:TAG_BITS];
			rsp_max_tag_q <= max_q[TAG_BITS-1:0];
			rsp_cnt_q     <= cnt_q;
			rsp_status_q  <= status_q;
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = rsp_v_q;
	assign rsp.min_key  = rsp_min_key_q;
	assign rsp.min_tag  = rsp_min_tag_q;
	assign rsp.max_key  = rsp_max_key_q;
	assign rsp.max_tag  = rsp_max_tag_q;
	assign rsp.count    = rsp_cnt_q;
	assign rsp.is_empty = (rsp_cnt_q == '0);
	assign rsp.status   = rsp_status_q;
endmodule

// File: src/dep_checker.sv
// ----------------------------------------------------------------------------
// dep_checker
// Port-level checks of the double-ended priority queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dep_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [dep_pkg::KEY_BITS-1:0] rsp_min_key,
	input logic signed [dep_pkg::KEY_BITS-1:0] rsp_max_key,
	input logic [dep_pkg::CNT_W-1:0]          rsp_count,
	input logic                               rsp_is_empty,
	input dep_pkg::status_t                   rsp_status
);
	import dep_pkg::*;

	// hold a response beat until taken
	`ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count))
	`ASSERT_IMP(a_empty_flag, rsp_valid, rsp_is_empty == (rsp_count == '0))
	`ASSERT_IMP(a_empty_zero, rsp_valid && rsp_is_empty, rsp_min_key == '0 && rsp_max_key == '0)
	`ASSERT_IMP(a_full_drop, rsp_valid && rsp_status == ST_FULL, rsp_count == CNT_W'(DEPTH))
	`ASSERT_IMP(a_order, rsp_valid && !rsp_is_empty, rsp_min_key <= rsp_max_key)
endmodule

bind double_ended_priority_queue dep_checker u_dep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_min_key  (rsp.min_key),
	.rsp_max_key  (rsp.max_key),
	.rsp_count    (rsp.count),
	.rsp_is_empty (rsp.is_empty),
	.rsp_status   (rsp.status)
);

// File: dv/double_ended_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb
// Self-checking bench for the double-ended priority queue. A directed table
// covers the empty store, extreme keys and tags, duplicates and deletes on an
// empty store; a fill to capacity and random operation mixes follow. A sorted queue
// model in the bench predicts every response, compared field by field.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dep_pkg::*;

	localparam int WATCHDOG_CYCLES = 20000;

	typedef struct packed {
		logic signed [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0]        tag;
	} pair_t;

	typedef struct {
		logic signed [KEY_BITS-1:0] min_key;
		logic [TAG_BITS-1:0]        min_tag;
		logic signed [KEY_BITS-1:0] max_key;
		logic [TAG_BITS-1:0]        max_tag;
		logic [CNT_W-1:0]           count;
		logic                       is_empty;
		status_t                    status;
	} answer_t;

	// One directed row; chk_st set means the typed status is checked directly.
	typedef struct {
		opcode_t                    op;
		logic signed [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0]        tag;
		bit                         chk_st;
		status_t                    st;
	} row_t;

	logic clk;
	logic arst_n;
	dep_req_if req ();
	dep_rsp_if rsp ();

	double_ended_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	pair_t   sorted_pairs[$];
	answer_t expected_answers[$];
	int      errors;
	int      send_idle_pct;
	int      recv_idle_pct;
	int      stall_cycles;
	row_t    rows[$];

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit pair_less(pair_t a, pair_t b);
		if (a.key != b.key)
			return a.key < b.key;
		return a.tag < b.tag;
	endfunction

	// Apply one operation to the sorted model and return the response it gives.
	function automatic answer_t apply_operation(opcode_t op, pair_t p);
		answer_t a;
		int      pos;
		bit      dup;
		a.status = ST_DONE;
		case (op)
			OP_INSERT: begin
				pos = 0;
				dup = 1'b0;
				while (pos < sorted_pairs.size()) begin
					if (sorted_pairs[pos] == p) begin
						dup = 1'b1;
						break;
					end
					if (pair_less(p, sorted_pairs[pos]))
						break;
					pos++;
				end
				if (dup)
					a.status = ST_DUPLICATE;
				else if (sorted_pairs.size() >= DEPTH)
					a.status = ST_FULL;
				else
					sorted_pairs.insert(pos, p);
			end
			OP_DEL_MIN: begin
				if (sorted_pairs.size() == 0)
					a.status = ST_EMPTY;
				else
					void'(sorted_pairs.pop_front());
			end
			OP_DEL_MAX: begin
				if (sorted_pairs.size() == 0)
					a.status = ST_EMPTY;
				else
					void'(sorted_pairs.pop_back());
			end
			default: ;
		endcase
		if (sorted_pairs.size() == 0) begin
			a.min_key = '0;
			a.min_tag = '0;
			a.max_key = '0;
			a.max_tag = '0;
		end else begin
			a.min_key = sorted_pairs[0].key;
			a.min_tag = sorted_pairs[0].tag;
			a.max_key = sorted_pairs[$].key;
			a.max_tag = sorted_pairs[$].tag;
		end
		a.count    = CNT_W'(sorted_pairs.size());
		a.is_empty = sorted_pairs.size() == 0;
		return a;
	endfunction

	// Drive one beat, with a random gap before it, and hold until accepted.
	// Valid stays high on return; the next beat or the caller drops it.
	task automatic send_beat(opcode_t op, logic signed [KEY_BITS-1:0] k,
		logic [TAG_BITS-1:0] t, bit chk_st, status_t st);
		answer_t a;
		pair_t   p;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		p.key = k;
		p.tag = t;
		a = apply_operation(op, p);
		if (chk_st && a.status != st) begin
			$display("%0t: table status expected %0d, model %0d", $time, st, a.status);
			errors++;
		end
		expected_answers.insert(expected_answers.size(), a);
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.key    <= k;
		req.tag    <= t;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	function automatic logic signed [KEY_BITS-1:0] random_key(int span);
		case ($urandom_range(3))
			0: return $signed($urandom);
			1: return $signed(KEY_BITS'({$urandom_range(1), {(KEY_BITS-1){1'b0}}}
				^ KEY_BITS'($urandom_range(3))));
			default: return KEY_BITS'($urandom_range(span)) - KEY_BITS'(span / 2);
		endcase
	endfunction

	task automatic random_phase(int n);
		int      roll;
		opcode_t op;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			// Lean toward inserts while the store is low, deletes when it is high.
			if (roll < (sorted_pairs.size() < 40 ? 55 : 30))
				op = OP_INSERT;
			else if (roll < 77)
				op = OP_DEL_MIN;
			else if (roll < 94)
				op = OP_DEL_MAX;
			else
				op = OP_QUERY;
			if (op == OP_INSERT && sorted_pairs.size() > 0 && $urandom_range(9) == 0)
				send_beat(op, sorted_pairs[$urandom_range(sorted_pairs.size() - 1)].key,
					sorted_pairs[$urandom_range(sorted_pairs.size() - 1)].tag, 0, ST_DONE);
			else
				send_beat(op, random_key(40), TAG_BITS'($urandom_range(7) == 0 ?
					$urandom : $urandom_range(3)), 0, ST_DONE);
		end
	endtask

	// Receiver: random stalls, compare each beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= $urandom_range(99) >= recv_idle_pct;
			if (rsp.valid && rsp.ready) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: response with nothing expected", $time);
					errors++;
				end else begin
					e = expected_answers.pop_front();
					if (rsp.min_key !== e.min_key || rsp.min_tag !== e.min_tag ||
						rsp.max_key !== e.max_key || rsp.max_tag !== e.max_tag ||
						rsp.count !== e.count || rsp.is_empty !== e.is_empty ||
						rsp.status !== e.status) begin
						$display("%0t: expected min %0d/%0d max %0d/%0d cnt %0d emp %0b st %0d",
							$time, e.min_key, e.min_tag, e.max_key, e.max_tag, e.count,
							e.is_empty, e.status);
						$display("%0t: actual   min %0d/%0d max %0d/%0d cnt %0d emp %0b st %0d",
							$time, rsp.min_key, rsp.min_tag, rsp.max_key, rsp.max_tag,
							rsp.count, rsp.is_empty, rsp.status);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: end the run after too long with no beat on either side.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > WATCHDOG_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic signed [KEY_BITS-1:0] kmin;
		logic signed [KEY_BITS-1:0] kmax;
		kmin = {1'b1, {(KEY_BITS-1){1'b0}}};
		kmax = {1'b0, {(KEY_BITS-1){1'b1}}};
		errors        = 0;
		stall_cycles  = 0;
		send_idle_pct = 32;
		recv_idle_pct = 84;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.opcode    = OP_QUERY;
		req.key       = '0;
		req.tag       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{OP_QUERY,   0,    0,      1, ST_DONE},
			'{OP_DEL_MIN, 0,    0,      1, ST_EMPTY},
			'{OP_DEL_MAX, 0,    0,      1, ST_EMPTY},
			'{OP_INSERT,  kmax, 16'hFFFF, 1, ST_DONE},
			'{OP_INSERT,  kmin, 16'h0000, 1, ST_DONE},
			'{OP_INSERT,  kmax, 16'hFFFF, 1, ST_DUPLICATE},
			'{OP_INSERT,  kmin, 16'hFFFF, 1, ST_DONE},
			'{OP_INSERT,  -1,   16'h5555, 1, ST_DONE},
			'{OP_INSERT,  -1,   16'hAAAA, 1, ST_DONE},
			'{OP_INSERT,  0,    0,        1, ST_DONE},
			'{OP_QUERY,   5,    5,        1, ST_DONE},
			'{OP_DEL_MIN, 0,    0,        1, ST_DONE},
			'{OP_DEL_MAX, 0,    0,        1, ST_DONE},
			'{OP_DEL_MIN, 0,    0,        0, ST_DONE},
			'{OP_DEL_MAX, 0,    0,        0, ST_DONE},
			'{OP_DEL_MIN, 0,    0,        0, ST_DONE},
			'{OP_DEL_MAX, 0,    0,        0, ST_DONE},
			'{OP_DEL_MIN, 0,    0,        1, ST_EMPTY}
		};
		foreach (rows[i])
			send_beat(rows[i].op, rows[i].key, rows[i].tag, rows[i].chk_st, rows[i].st);

		// Fill to capacity, then hit it with a fresh pair and a duplicate.
		for (int i = 0; i < DEPTH; i++)
			send_beat(OP_INSERT, KEY_BITS'(DEPTH - i), TAG_BITS'(i), 0, ST_DONE);
		send_beat(OP_INSERT, kmin, '0, 1, ST_FULL);
		send_beat(OP_INSERT, KEY_BITS'(DEPTH), '0, 1, ST_DUPLICATE);
		// Hold until every expected response has been received.
		req.valid <= 1'b0;
		wait (expected_answers.size() == 0);
		random_phase(450);
		send_idle_pct = 84;
		recv_idle_pct = 32;
		random_phase(450);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(450);

		req.valid <= 1'b0;
		wait (expected_answers.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
